### hdl/ggnh_pkg.sv
// Shared definitions for the greedy geographic next-hop table.
// Holds request and configuration codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ggnh_pkg;

    // Request kinds carried in req_type
    localparam logic REQ_SET   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Configuration register indexes
    localparam int  CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_Y = 1'b1;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

`default_nettype wire

### hdl/ggnh_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the neighbour table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ggnh_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic                                 re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/ggnh_dist.sv
// Shared squared-distance unit: three-stage pipeline (difference, square, sum).
// Carries a tag alongside each beat. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ggnh_dist #(
    parameter int COORD_BITS = 16,
    parameter int TAG_W      = 17
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    flush,
    input  wire logic                    in_valid,
    input  wire logic [COORD_BITS-1:0]   ax,
    input  wire logic [COORD_BITS-1:0]   ay,
    input  wire logic [COORD_BITS-1:0]   bx,
    input  wire logic [COORD_BITS-1:0]   by,
    input  wire logic [TAG_W-1:0]        in_tag,
    output logic                         out_valid,
    output logic [2*COORD_BITS:0]        dist_sq,
    output logic [TAG_W-1:0]             out_tag,
    output logic                         busy
);

    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int DIST_W = SQ_W + 1;

    logic                  v1_reg, v2_reg, v3_reg;
    logic                  v1_next, v2_next, v3_next;
    logic [COORD_BITS-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic [SQ_W-1:0]       sqx_reg, sqy_reg, sqx_next, sqy_next;
    logic [DIST_W-1:0]     sum_reg, sum_next;
    logic [TAG_W-1:0]      t1_reg, t2_reg, t3_reg;

    // Stage datapath
    always_comb
    begin
        dx_next  = (ax >= bx) ? (ax - bx) : (bx - ax);
        dy_next  = (ay >= by) ? (ay - by) : (by - ay);
        sqx_next = SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_next = SQ_W'(dy_reg) * SQ_W'(dy_reg);
        sum_next = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);
        v1_next  = in_valid && !flush;
        v2_next  = v1_reg && !flush;
        v3_next  = v2_reg && !flush;
    end

    // Advance valid flags; drop everything on flush
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        t1_reg  <= in_tag;
        sqx_reg <= sqx_next;
        sqy_reg <= sqy_next;
        t2_reg  <= t1_reg;
        sum_reg <= sum_next;
        t3_reg  <= t2_reg;
    end

    assign out_valid = v3_reg;
    assign dist_sq   = sum_reg;
    assign out_tag   = t3_reg;
    assign busy      = v1_reg || v2_reg || v3_reg;

endmodule

`default_nettype wire

### hdl/greedy_geo_next_hop_table.sv
// Greedy geographic next-hop table: top level with sequencer and result register.
// Depends on ggnh_pkg, ggnh_ram and ggnh_dist.
`timescale 1ns / 1ps
`default_nettype none

// Neighbour table for greedy geographic forwarding. A set beat (req_type 0)
// updates the position of a known address or appends a new neighbour if
// there is room; a query beat (req_type 1) returns the destination itself if
// it is a neighbour, else the stored neighbour closest to it (squared
// distance) if strictly closer than this node, the earlier entry winning a
// tie. Each beat scans the N stored entries one per cycle through the single
// table read port, stopping early on an address match; a query also waits
// for the three-stage distance pipeline to drain. in_ready is high only while
// the sequencer is idle; a finished result may wait in the output register
// while the next beat is taken. own_x and own_y are written by the user via
// cfg_we / cfg_index / cfg_wdata only while the block is idle (not enforced).
module greedy_geo_next_hop_table #(
    parameter int MAX_NEIGHBORS = 64,
    parameter int ADDR_BITS     = 16,
    parameter int COORD_BITS    = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [ggnh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [COORD_BITS-1:0]            cfg_wdata,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             req_type,
    input  wire logic [ADDR_BITS-1:0]             node_addr,
    input  wire logic [COORD_BITS-1:0]            coord_x,
    input  wire logic [COORD_BITS-1:0]            coord_y,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [ADDR_BITS-1:0]                  hop_addr,
    output logic                                  hop_found,
    output logic                                  entry_added,
    output logic                                  table_full
);

    import ggnh_pkg::*;

    localparam int IDX_W  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int CNT_W  = $clog2(MAX_NEIGHBORS + 1);
    localparam int REC_W  = ADDR_BITS + 2 * COORD_BITS;
    localparam int DIST_W = 2 * COORD_BITS + 1;
    localparam int TAG_W  = ADDR_BITS + 1;

    state_t                 state_reg, state_next;
    logic [COORD_BITS-1:0]  own_x_reg, own_y_reg;
    logic                   req_reg, req_next;
    logic [ADDR_BITS-1:0]   dest_addr_reg, dest_addr_next;
    logic [COORD_BITS-1:0]  dest_x_reg, dest_x_next, dest_y_reg, dest_y_next;
    logic [CNT_W-1:0]       count_reg, count_next, rd_cnt_reg, rd_cnt_next;
    logic                   rvalid_reg, rvalid_next;
    logic [IDX_W-1:0]       ridx_reg, ridx_next;
    logic [DIST_W-1:0]      best_reg, best_next;
    logic [ADDR_BITS-1:0]   hop_reg, hop_next;
    logic                   found_reg, found_next, added_reg, added_next;
    logic                   full_reg, full_next;
    logic                   out_valid_reg, out_valid_next;
    logic [ADDR_BITS-1:0]   hop_addr_reg, hop_addr_next;
    logic                   hop_found_reg, hop_found_next;
    logic                   entry_added_reg, entry_added_next;
    logic                   table_full_reg, table_full_next;

    logic                   rd_en, hit, scan_end, has_room;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [REC_W-1:0]       ram_rdata;
    logic [ADDR_BITS-1:0]   rec_addr;
    logic [COORD_BITS-1:0]  rec_x, rec_y;

    logic                   d_in_valid, d_out_valid, d_busy, d_flush;
    logic [COORD_BITS-1:0]  d_ax, d_ay, d_bx, d_by;
    logic [TAG_W-1:0]       d_in_tag, d_out_tag;
    logic [DIST_W-1:0]      d_dist;

    // Unpack the table record
    assign rec_addr = ram_rdata[REC_W-1 -: ADDR_BITS];
    assign rec_x    = ram_rdata[2*COORD_BITS-1 -: COORD_BITS];
    assign rec_y    = ram_rdata[COORD_BITS-1:0];

    // Scan control
    assign rd_en    = (state_reg == ST_SCAN) && (rd_cnt_reg < count_reg);
    assign hit      = (state_reg == ST_SCAN) && rvalid_reg && (rec_addr == dest_addr_reg);
    assign scan_end = (rd_cnt_reg == count_reg) && !rvalid_reg && !d_busy;
    assign has_room = count_reg < CNT_W'(MAX_NEIGHBORS);

    // Table write: update on a set hit, append at the end of a set scan if there is room
    assign ram_we = (state_reg == ST_SCAN) && (req_reg == REQ_SET)
                  && (hit || (scan_end && has_room));
    assign ram_waddr = hit ? ridx_reg : count_reg[IDX_W-1:0];

    // Feed the distance unit: own position on query start, then each entry
    always_comb
    begin
        d_in_valid = 1'b0;
        d_ax       = dest_x_reg;
        d_ay       = dest_y_reg;
        d_bx       = rec_x;
        d_by       = rec_y;
        d_in_tag   = {1'b0, rec_addr};
        if (state_reg == ST_IDLE)
        begin
            d_in_valid = in_valid && (req_type == REQ_QUERY);
            d_ax       = coord_x;
            d_ay       = coord_y;
            d_bx       = own_x_reg;
            d_by       = own_y_reg;
            d_in_tag   = {1'b1, {ADDR_BITS{1'b0}}};
        end
        else if (state_reg == ST_SCAN)
        begin
            d_in_valid = rvalid_reg && !hit && (req_reg == REQ_QUERY);
        end
    end

    assign d_flush = hit && (req_reg == REQ_QUERY);

    ggnh_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_NEIGHBORS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({dest_addr_reg, dest_x_reg, dest_y_reg}),
        .re    (rd_en),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    ggnh_dist #(
        .COORD_BITS (COORD_BITS),
        .TAG_W      (TAG_W)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .flush     (d_flush),
        .in_valid  (d_in_valid),
        .ax        (d_ax),
        .ay        (d_ay),
        .bx        (d_bx),
        .by        (d_by),
        .in_tag    (d_in_tag),
        .out_valid (d_out_valid),
        .dist_sq   (d_dist),
        .out_tag   (d_out_tag),
        .busy      (d_busy)
    );

    // Sequencer and next-state logic
    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        dest_addr_next   = dest_addr_reg;
        dest_x_next      = dest_x_reg;
        dest_y_next      = dest_y_reg;
        count_next       = count_reg;
        rd_cnt_next      = rd_cnt_reg;
        rvalid_next      = 1'b0;
        ridx_next        = ridx_reg;
        best_next        = best_reg;
        hop_next         = hop_reg;
        found_next       = found_reg;
        added_next       = added_reg;
        full_next        = full_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        hop_addr_next    = hop_addr_reg;
        hop_found_next   = hop_found_reg;
        entry_added_next = entry_added_reg;
        table_full_next  = table_full_reg;

        case (state_reg)
            ST_IDLE:
            begin
                // Take a beat and clear the per-item result
                if (in_valid)
                begin
                    req_next       = req_type;
                    dest_addr_next = node_addr;
                    dest_x_next    = coord_x;
                    dest_y_next    = coord_y;
                    rd_cnt_next    = '0;
                    hop_next       = '0;
                    found_next     = 1'b0;
                    added_next     = 1'b0;
                    full_next      = 1'b0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Advance the read pointer
                if (rd_en)
                begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                rvalid_next = rd_en;
                ridx_next   = rd_cnt_reg[IDX_W-1:0];

                // Track the best distance so far
                if (d_out_valid)
                begin
                    if (d_out_tag[TAG_W-1])
                    begin
                        best_next = d_dist;
                    end
                    else if (d_dist < best_reg)
                    begin
                        best_next  = d_dist;
                        hop_next   = d_out_tag[ADDR_BITS-1:0];
                        found_next = 1'b1;
                    end
                end

                if (hit)
                begin
                    rvalid_next = 1'b0;
                    state_next  = ST_DONE;
                    if (req_reg == REQ_QUERY)
                    begin
                        hop_next   = rec_addr;
                        found_next = 1'b1;
                    end
                end
                else if (scan_end)
                begin
                    state_next = ST_DONE;
                    if (req_reg == REQ_SET)
                    begin
                        if (has_room)
                        begin
                            count_next = count_reg + CNT_W'(1);
                            added_next = 1'b1;
                        end
                        else
                        begin
                            full_next = 1'b1;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    hop_addr_next    = hop_reg;
                    hop_found_next   = found_reg;
                    entry_added_next = added_reg;
                    table_full_next  = full_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_cnt_reg    <= '0;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_cnt_reg    <= rd_cnt_next;
            rvalid_reg    <= rvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_x_reg <= '0;
            own_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OWN_X: own_x_reg <= cfg_wdata;
                CFG_OWN_Y: own_y_reg <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        dest_addr_reg   <= dest_addr_next;
        dest_x_reg      <= dest_x_next;
        dest_y_reg      <= dest_y_next;
        ridx_reg        <= ridx_next;
        best_reg        <= best_next;
        hop_reg         <= hop_next;
        found_reg       <= found_next;
        added_reg       <= added_next;
        full_reg        <= full_next;
        hop_addr_reg    <= hop_addr_next;
        hop_found_reg   <= hop_found_next;
        entry_added_reg <= entry_added_next;
        table_full_reg  <= table_full_next;
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign hop_addr    = hop_addr_reg;
    assign hop_found   = hop_found_reg;
    assign entry_added = entry_added_reg;
    assign table_full  = table_full_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_NEIGHBORS))
        else $error("neighbour count beyond table depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("neighbour count moved by other than one");

    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hop_found) |-> (!entry_added && !table_full))
        else $error("query result carries set flags");

    a_add_or_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(entry_added && table_full))
        else $error("set both added and dropped");

    a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_SCAN && rd_cnt_reg == '0))
        else $error("accepted beat did not start a scan");
`endif

endmodule

`default_nettype wire
